// ----- src/ycbcr_to_packed_rgb_pixel_top_assert.svh -----
// ------------------------------------------------------------------------
// ycbcr to packed rgb pixel assertion macros
// shared property forms for the converter checks
// ------------------------------------------------------------------------
`ifndef YCBCR_TO_PACKED_RGB_PIXEL_TOP_ASSERT_SVH
`define YCBCR_TO_PACKED_RGB_PIXEL_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define YCRGB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define YCRGB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ycrgb_pkg.sv -----
// ------------------------------------------------------------------------
// ycrgb_pkg
// constants, register indexes and conversion tables for the ycbcr to rgb
// pixel converter
// ------------------------------------------------------------------------
package ycrgb_pkg;

    localparam int PIXEL_BITS_DEF = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMITED_RANGE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_LOSSES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_SHIFTS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_INPUT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_PIXEL    = 3'd4;

    localparam int TERM_W = 10;
    localparam int SUM_W  = 11;

    localparam logic [7:0] ALPHA_CONST = 8'hFF;
    localparam logic [7:0] LIM_LO      = 8'd16;
    localparam logic [7:0] LIM_HI      = 8'd235;
    localparam logic [7:0] FULL_HI     = 8'd255;

    typedef logic signed [TERM_W-1:0] t_term;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef t_term                    t_term_tbl [256];
    typedef logic [7:0]               t_byte_tbl [256];

    // chroma byte index i stands for c = i - 128, truncation toward zero
    function automatic t_term_tbl build_red_tbl();
        t_term_tbl t;
        int c;
        for (int i = 0; i < 256; i++) begin
            c = i - 128;
            t[i] = TERM_W'((419 * c) / 299);
        end
        return t;
    endfunction

    function automatic t_term_tbl build_grn_cr_tbl();
        t_term_tbl t;
        int c;
        for (int i = 0; i < 256; i++) begin
            c = i - 128;
            t[i] = TERM_W'((-299 * c) / 419);
        end
        return t;
    endfunction

    function automatic t_term_tbl build_grn_cb_tbl();
        t_term_tbl t;
        int c;
        for (int i = 0; i < 256; i++) begin
            c = i - 128;
            t[i] = TERM_W'((-114 * c) / 331);
        end
        return t;
    endfunction

    function automatic t_term_tbl build_blu_tbl();
        t_term_tbl t;
        int c;
        for (int i = 0; i < 256; i++) begin
            c = i - 128;
            t[i] = TERM_W'((587 * c) / 331);
        end
        return t;
    endfunction

    // studio range expansion, only 16..235 are ever looked up
    function automatic t_byte_tbl build_expand_tbl();
        t_byte_tbl t;
        int x;
        for (int i = 0; i < 256; i++) begin
            x = (i < 16) ? 16 : ((i > 235) ? 235 : i);
            t[i] = 8'(((x - 16) * 255) / 219);
        end
        return t;
    endfunction

    localparam t_term_tbl RED_TBL    = build_red_tbl();
    localparam t_term_tbl GRN_CR_TBL = build_grn_cr_tbl();
    localparam t_term_tbl GRN_CB_TBL = build_grn_cb_tbl();
    localparam t_term_tbl BLU_TBL    = build_blu_tbl();
    localparam t_byte_tbl EXPAND_TBL = build_expand_tbl();

    function automatic logic [7:0] clamp_byte(input t_sum v, input logic limited);
        t_sum lo;
        t_sum hi;
        lo = limited ? t_sum'({3'b000, LIM_LO}) : '0;
        hi = limited ? t_sum'({3'b000, LIM_HI}) : t_sum'({3'b000, FULL_HI});
        if (v < lo) begin
            return lo[7:0];
        end else if (v > hi) begin
            return hi[7:0];
        end
        return v[7:0];
    endfunction

    function automatic logic [31:0] place(input logic [7:0] b, input logic [3:0] loss,
                                          input logic [4:0] sh);
        logic [7:0] kept;
        kept = b >> loss;
        return {24'h0, kept} << sh;
    endfunction

endpackage

// ----- src/ycbcr_to_packed_rgb_pixel_top.sv -----
// ------------------------------------------------------------------------
// ycbcr to packed rgb pixel converter
// converts one luma/chroma/alpha beat into one packed, shifted rgba pixel
// ------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled.
// Four register stages carry the work: chroma term lookup and green sum,
// luma add and clamp, studio range expansion, then channel placement and
// masking into the output register. The throughput of one beat per clock
// holds while the output is not stalled; a stall on the output lets empty
// stages close up and then holds every stage in place, and the input takes
// a new beat whenever stage one frees up. Configuration is to be written
// through the plain write port while idle; the block does not enforce this.
`include "ycbcr_to_packed_rgb_pixel_top_assert.svh"

module ycbcr_to_packed_rgb_pixel_top #(
    parameter int PIXEL_BITS = ycrgb_pkg::PIXEL_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ycrgb_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [ycrgb_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // luma [7:0], chroma_blue [15:8], chroma_red [23:16], alpha [31:24]
    input  logic [31:0]                           i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // pixel [PIXEL_BITS-1:0], zero filled to whole bytes
    output logic [((PIXEL_BITS+7)/8)*8-1:0]       o_m_axis_tdata
);
    import ycrgb_pkg::*;

    localparam int OUT_W = ((PIXEL_BITS + 7) / 8) * 8;

    // configuration
    logic        r_limited;
    logic [15:0] r_losses;
    logic [19:0] r_shifts;
    logic        r_alpha_in;
    logic        r_wide_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limited    <= 1'b0;
            r_losses     <= '0;
            r_shifts     <= '0;
            r_alpha_in   <= 1'b0;
            r_wide_pixel <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_LIMITED_RANGE: r_limited    <= i_cfg_wdata[0];
                CFG_CHAN_LOSSES:   r_losses     <= i_cfg_wdata[15:0];
                CFG_CHAN_SHIFTS:   r_shifts     <= i_cfg_wdata[19:0];
                CFG_ALPHA_INPUT:   r_alpha_in   <= i_cfg_wdata[0];
                CFG_WIDE_PIXEL:    r_wide_pixel <= i_cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    // stage valids and ready chain
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic w_out_ready, w_s3_ready, w_s2_ready, w_s1_ready;

    assign w_out_ready     = !r_out_valid || i_m_axis_tready;
    assign w_s3_ready      = !r_s3_valid || w_out_ready;
    assign w_s2_ready      = !r_s2_valid || w_s3_ready;
    assign w_s1_ready      = !r_s1_valid || w_s2_ready;
    assign o_s_axis_tready = w_s1_ready;
    assign o_m_axis_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_s1_valid <= i_s_axis_tvalid;
            end
            if (w_s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_s3_ready) begin
                r_s3_valid <= r_s2_valid;
            end
            if (w_out_ready) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    // stage 1: chroma terms from tables
    logic [7:0] w_luma, w_cb, w_cr, w_alpha;
    t_term      n_s1_red, n_s1_grn, n_s1_blu;
    logic [7:0] n_s1_alpha;
    logic [7:0] r_s1_luma, r_s1_alpha;
    t_term      r_s1_red, r_s1_grn, r_s1_blu;

    assign w_luma  = i_s_axis_tdata[7:0];
    assign w_cb    = i_s_axis_tdata[15:8];
    assign w_cr    = i_s_axis_tdata[23:16];
    assign w_alpha = i_s_axis_tdata[31:24];

    always_comb begin
        n_s1_red   = RED_TBL[w_cr];
        n_s1_grn   = GRN_CR_TBL[w_cr] + GRN_CB_TBL[w_cb];
        n_s1_blu   = BLU_TBL[w_cb];
        n_s1_alpha = r_alpha_in ? w_alpha : ALPHA_CONST;
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready && i_s_axis_tvalid) begin
            r_s1_luma  <= w_luma;
            r_s1_alpha <= n_s1_alpha;
            r_s1_red   <= n_s1_red;
            r_s1_grn   <= n_s1_grn;
            r_s1_blu   <= n_s1_blu;
        end
    end

    // stage 2: add luma and clamp
    t_sum       w_luma_ext;
    logic [7:0] n_s2_red, n_s2_grn, n_s2_blu;
    logic [7:0] r_s2_red, r_s2_grn, r_s2_blu, r_s2_alpha;

    assign w_luma_ext = t_sum'({3'b000, r_s1_luma});

    always_comb begin
        n_s2_red = clamp_byte(w_luma_ext + SUM_W'(r_s1_red), r_limited);
        n_s2_grn = clamp_byte(w_luma_ext + SUM_W'(r_s1_grn), r_limited);
        n_s2_blu = clamp_byte(w_luma_ext + SUM_W'(r_s1_blu), r_limited);
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_ready && r_s1_valid) begin
            r_s2_red   <= n_s2_red;
            r_s2_grn   <= n_s2_grn;
            r_s2_blu   <= n_s2_blu;
            r_s2_alpha <= r_s1_alpha;
        end
    end

    // stage 3: studio range expansion
    logic [7:0] r_s3_red, r_s3_grn, r_s3_blu, r_s3_alpha;

    always_ff @(posedge i_clk) begin
        if (w_s3_ready && r_s2_valid) begin
            r_s3_red   <= r_limited ? EXPAND_TBL[r_s2_red] : r_s2_red;
            r_s3_grn   <= r_limited ? EXPAND_TBL[r_s2_grn] : r_s2_grn;
            r_s3_blu   <= r_limited ? EXPAND_TBL[r_s2_blu] : r_s2_blu;
            r_s3_alpha <= r_s2_alpha;
        end
    end

    // stage 4: place channels, mask to pixel width
    logic [31:0]           w_packed;
    logic [PIXEL_BITS-1:0] n_pixel;
    logic [OUT_W-1:0]      r_out_pixel;

    always_comb begin
        w_packed = place(r_s3_red,   r_losses[3:0],   r_shifts[4:0])
                 | place(r_s3_grn,   r_losses[7:4],   r_shifts[9:5])
                 | place(r_s3_blu,   r_losses[11:8],  r_shifts[14:10])
                 | place(r_s3_alpha, r_losses[15:12], r_shifts[19:15]);
        n_pixel  = w_packed[PIXEL_BITS-1:0];
        if (!r_wide_pixel) begin
            n_pixel = n_pixel & PIXEL_BITS'(16'hFFFF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && r_s3_valid) begin
            r_out_pixel <= OUT_W'(n_pixel);
        end
    end

    assign o_m_axis_tdata = r_out_pixel;

    // checks
    `YCRGB_ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, r_s1_valid, "accepted beat missing in stage 1")
    `YCRGB_ASSERT_NOW(a_studio_clamp, i_clk, i_rst_n, r_s2_valid && r_limited,
        (r_s2_red >= LIM_LO) && (r_s2_red <= LIM_HI) &&
        (r_s2_grn >= LIM_LO) && (r_s2_grn <= LIM_HI) &&
        (r_s2_blu >= LIM_LO) && (r_s2_blu <= LIM_HI), "studio clamp out of range")
    `YCRGB_ASSERT_NOW(a_narrow_mask, i_clk, i_rst_n, o_m_axis_tvalid && !r_wide_pixel,
        (o_m_axis_tdata >> 16) == '0, "narrow pixel has upper bits set")

endmodule
